@@ src/cubic_bspline_point_eval_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: assertion macros
// Shared check forms; expect clk and rst_n in the including scope.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_POINT_EVAL_UNIT_MACROS_SVH
`define CUBIC_BSPLINE_POINT_EVAL_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cubic bspline check failed");

// Consequent must hold in the cycle after the antecedent.
`define CBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cubic bspline check failed");

`endif

@@ src/cbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: package
// Payload types, datapath widths and constants shared by all modules.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int COORD_W  = 20;   // signed Q16.4 coordinate
    localparam int FRAC_W   = 16;   // unsigned Q0.16 segment position
    localparam int COEF_W   = COORD_W + 4;
    localparam int ACC1_W   = COORD_W + FRAC_W + 5;
    localparam int ACC2_W   = COORD_W + 2 * FRAC_W + 6;
    localparam int ACC3_W   = COORD_W + 3 * FRAC_W + 7;
    localparam int CHUNK_W  = 32;   // operand slice per partial product
    localparam int T_W      = ACC3_W - 3 * FRAC_W;
    localparam int W_W      = COORD_W + 3;
    localparam int V_W      = COORD_W + 2;
    localparam int DIV_K    = COORD_W + 3;
    localparam int PIPE_DEPTH = 10;

    // ceil(2^DIV_K / 3): exact floor division by three for V_W-bit operands
    localparam logic [V_W-1:0] RECIP3 = V_W'(((64'd1 << DIV_K) / 64'd3) + 64'd1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [FRAC_W-1:0]         frac_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p3_x;
        coord_t p3_y;
        frac_t  frac_u;
    } item_t;

    typedef struct packed {
        coord_t curve_x;
        coord_t curve_y;
    } point_t;

endpackage

@@ src/cbs_horner_step.sv @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: Horner step
// Two stages: acc * u as registered partial products, then sum plus the
// aligned next coefficient.
// ----------------------------------------------------------------------------
module cbs_horner_step
    import cbs_pkg::*;
#(
    parameter int ACC_W = COEF_W,
    parameter int RES_W = ACC1_W,
    parameter int SHIFT = FRAC_W
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ACC_W-1:0] acc,
    input  coef_t                   addend,
    input  frac_t                   f,
    output logic signed [RES_W-1:0] acc_out,
    output frac_t                   f_out
);

    localparam int NCH  = (ACC_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW = NCH * CHUNK_W;
    localparam int PRW  = CHUNK_W + FRAC_W + 1;
    localparam int PW   = PADW + FRAC_W + 1;

    logic signed [PADW-1:0] acc_pad;
    logic signed [PRW-1:0]  prod_next [NCH];
    logic signed [PRW-1:0]  prod_reg  [NCH];
    coef_t                  add_reg;
    frac_t                  f_a_reg;
    logic signed [PW-1:0]   psum;
    logic signed [RES_W-1:0] acc_next;
    logic signed [RES_W-1:0] acc_reg;
    frac_t                  f_b_reg;

    assign acc_pad = PADW'(acc);

    // low slices are unsigned, the top slice carries the sign
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            if (i == NCH - 1)
            begin
                prod_next[i] = $signed({{(FRAC_W + 1){acc_pad[i * CHUNK_W + CHUNK_W - 1]}},
                                        acc_pad[i * CHUNK_W +: CHUNK_W]})
                             * $signed({{(CHUNK_W + 1){1'b0}}, f});
            end
            else
            begin
                prod_next[i] = $signed({1'b0, {{FRAC_W{1'b0}}, acc_pad[i * CHUNK_W +: CHUNK_W]}
                                              * {{CHUNK_W{1'b0}}, f}});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            add_reg <= addend;
            f_a_reg <= f;
        end
    end

    always_comb
    begin
        psum = '0;
        for (int i = 0; i < NCH; i++)
        begin
            psum = psum + (PW'(prod_reg[i]) <<< (i * CHUNK_W));
        end
        acc_next = $signed(psum[RES_W-1:0]) + (RES_W'(add_reg) <<< SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
            f_b_reg <= f_a_reg;
        end
    end

    assign acc_out = acc_reg;
    assign f_out   = f_b_reg;

endmodule

@@ src/cbs_div6.sv @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: scale and divide
// Drops the fraction of u^3, clamps, divides by six with a reciprocal
// multiply and registers the coordinate. Three stages.
// ----------------------------------------------------------------------------
module cbs_div6
    import cbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [ACC3_W-1:0] acc,
    output coord_t                   curve
);

    // floor(t/6) stays in range exactly when t lies in [-3*2^W, 3*2^W - 1]
    localparam logic signed [T_W-1:0] T_HI  = $signed((T_W'(3) << COORD_W) - T_W'(1));
    localparam logic signed [T_W-1:0] T_LO  = -$signed(T_W'(3) << COORD_W);
    localparam logic [T_W-1:0]        T_OFS = T_W'(3) << COORD_W;
    localparam logic [W_W-1:0]        W_MAX = (W_W'(6) << COORD_W) - W_W'(1);

    logic signed [T_W-1:0] t;
    logic [T_W-1:0]        t_ofs;
    logic [W_W-1:0]        w;
    logic [V_W-1:0]        v_reg;
    logic [2*V_W-1:0]      prod_reg;
    logic [COORD_W-1:0]    q;
    coord_t                curve_reg;

    assign t     = acc[ACC3_W-1 -: T_W];
    assign t_ofs = t + T_OFS;

    always_comb
    begin
        if (t > T_HI)
        begin
            w = W_MAX;
        end
        else if (t < T_LO)
        begin
            w = '0;
        end
        else
        begin
            w = t_ofs[W_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg     <= w[W_W-1:1];
            prod_reg  <= {{V_W{1'b0}}, v_reg} * {{V_W{1'b0}}, RECIP3};
            curve_reg <= $signed({~q[COORD_W-1], q[COORD_W-2:0]});
        end
    end

    // quotient is biased by half the range: flip the top bit to unbias
    assign q     = prod_reg[DIV_K +: COORD_W];
    assign curve = curve_reg;

endmodule

@@ src/cbs_axis.sv @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: one axis
// Coefficient stage, three Horner steps and the divide stage for a single
// coordinate; ten register stages in all.
// ----------------------------------------------------------------------------
module cbs_axis
    import cbs_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t p0,
    input  coord_t p1,
    input  coord_t p2,
    input  coord_t p3,
    input  frac_t  f,
    output coord_t curve
);

    coef_t e0, e1, e2, e3, d, s;
    coef_t c0_next, c1_next, c2_next, c3_next;
    coef_t c0_reg, c1_reg, c2_reg, c3_reg;
    frac_t f_reg;
    coef_t c1_pipe_reg [2];
    coef_t c0_pipe_reg [4];

    logic signed [ACC1_W-1:0] acc1;
    logic signed [ACC2_W-1:0] acc2;
    logic signed [ACC3_W-1:0] acc3;
    frac_t f1, f2, f3;

    assign e0 = COEF_W'(p0);
    assign e1 = COEF_W'(p1);
    assign e2 = COEF_W'(p2);
    assign e3 = COEF_W'(p3);
    assign d  = e2 - e0;
    assign s  = e0 - (e1 <<< 1) + e2;

    // c0 carries the rounding half (3 of 6) up front
    assign c0_next = e0 + (e1 <<< 2) + e2 + COEF_W'(3);
    assign c1_next = (d <<< 1) + d;
    assign c2_next = (s <<< 1) + s;
    assign c3_next = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
            f_reg  <= f;
            c1_pipe_reg[0] <= c1_reg;
            c1_pipe_reg[1] <= c1_pipe_reg[0];
            c0_pipe_reg[0] <= c0_reg;
            c0_pipe_reg[1] <= c0_pipe_reg[0];
            c0_pipe_reg[2] <= c0_pipe_reg[1];
            c0_pipe_reg[3] <= c0_pipe_reg[2];
        end
    end

    cbs_horner_step #(
        .ACC_W (COEF_W),
        .RES_W (ACC1_W),
        .SHIFT (FRAC_W)
    ) u_step1 (
        .clk     (clk),
        .en      (en),
        .acc     (c3_reg),
        .addend  (c2_reg),
        .f       (f_reg),
        .acc_out (acc1),
        .f_out   (f1)
    );

    cbs_horner_step #(
        .ACC_W (ACC1_W),
        .RES_W (ACC2_W),
        .SHIFT (2 * FRAC_W)
    ) u_step2 (
        .clk     (clk),
        .en      (en),
        .acc     (acc1),
        .addend  (c1_pipe_reg[1]),
        .f       (f1),
        .acc_out (acc2),
        .f_out   (f2)
    );

    cbs_horner_step #(
        .ACC_W (ACC2_W),
        .RES_W (ACC3_W),
        .SHIFT (3 * FRAC_W)
    ) u_step3 (
        .clk     (clk),
        .en      (en),
        .acc     (acc2),
        .addend  (c0_pipe_reg[3]),
        .f       (f2),
        .acc_out (acc3),
        .f_out   (f3)
    );

    cbs_div6 u_div6 (
        .clk   (clk),
        .en    (en),
        .acc   (acc3),
        .curve (curve)
    );

endmodule

@@ src/cubic_bspline_point_eval_unit.sv @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: top level
// Evaluates one uniform cubic B-spline segment point per transfer.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while the output is not stalled and returns
// points in order via a coefficient stage, three Horner steps of two stages
// each (partial products, then sum) and three stages to drop the fraction,
// clamp and divide by six. Coordinates are signed Q16.4, u is Q0.16; results
// round to nearest with ties upward and saturate. The whole pipeline holds
// while a finished point is stalled at the output, so item_stall follows
// point_stall in the same cycle whenever point_valid is high.
// ----------------------------------------------------------------------------
`include "cubic_bspline_point_eval_unit_macros.svh"

module cubic_bspline_point_eval_unit
    import cbs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output logic   point_valid,
    input  logic   point_stall,
    output point_t point
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic                  advance;
    coord_t                curve_x;
    coord_t                curve_y;

    // hold every stage while the finished point waits
    assign advance    = !(valid_reg[PIPE_DEPTH-1] && point_stall);
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    cbs_axis u_axis_x (
        .clk   (clk),
        .en    (advance),
        .p0    (item.p0_x),
        .p1    (item.p1_x),
        .p2    (item.p2_x),
        .p3    (item.p3_x),
        .f     (item.frac_u),
        .curve (curve_x)
    );

    cbs_axis u_axis_y (
        .clk   (clk),
        .en    (advance),
        .p0    (item.p0_y),
        .p1    (item.p1_y),
        .p2    (item.p2_y),
        .p3    (item.p3_y),
        .f     (item.frac_u),
        .curve (curve_y)
    );

    assign item_stall    = !advance;
    assign point_valid   = valid_reg[PIPE_DEPTH-1];
    assign point.curve_x = curve_x;
    assign point.curve_y = curve_y;

    `CBS_ASSERT_SAME(a_stall_from_output, item_stall, point_valid && point_stall)
    `CBS_ASSERT_NEXT(a_last_stage_moves, advance && valid_reg[PIPE_DEPTH-2], point_valid)
    `CBS_ASSERT_NEXT(a_no_phantom_entry, advance && !item_valid, !valid_reg[0])
    `CBS_ASSERT_NEXT(a_hold_keeps_valids, !advance, $stable(valid_reg))

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Cubic B-spline point evaluator: testbench
// Drives control-point sets and segment positions into the evaluator and
// checks every returned curve point against an exact rational predictor.
// The run covers a directed corner pass and four phases of random traffic
// with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb
    import cbs_pkg::*;
();

    localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer before giving up
    localparam int PHASE_ITEMS  = 162;
    localparam int SETTLE_TIME  = 2 * PIPE_DEPTH;
    localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    class point_scoreboard;
        point_t expected_pts[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Exact floor((N + 3 S^3) / (6 S^3)) on one axis, then clamp.
        function coord_t spline_axis(coord_t a0, coord_t a1, coord_t a2, coord_t a3,
                                     frac_t u);
            longint p0, p1, p2, p3, c0, c1, c2, c3, whole, q, bias, top, bottom;
            logic signed [127:0] k0, k1, k2, k3, fw, num, scaled;
            p0 = a0;
            p1 = a1;
            p2 = a2;
            p3 = a3;
            c0 = p0 + 4 * p1 + p2;
            c1 = 3 * (p2 - p0);
            c2 = 3 * (p0 - 2 * p1 + p2);
            c3 = -p0 + 3 * p1 - 3 * p2 + p3;
            k0 = c0;
            k1 = c1;
            k2 = c2;
            k3 = c3;
            fw = 0;
            fw[FRAC_W-1:0] = u;
            num = ((k3 * fw + (k2 <<< FRAC_W)) * fw + (k1 <<< (2 * FRAC_W))) * fw
                  + (k0 <<< (3 * FRAC_W));
            num = num + (128'sd3 <<< (3 * FRAC_W));
            scaled = num >>> (3 * FRAC_W);
            whole = scaled[63:0];
            // shift into positive range so the division floors
            bias = 64'sd1 <<< 40;
            q = (whole + 6 * bias) / 6 - bias;
            top = (64'sd1 <<< (COORD_W - 1)) - 1;
            bottom = -(64'sd1 <<< (COORD_W - 1));
            if (q > top)
                q = top;
            if (q < bottom)
                q = bottom;
            return q[COORD_W-1:0];
        endfunction

        function point_t eval_point(item_t it);
            point_t pt;
            pt.curve_x = spline_axis(it.p0_x, it.p1_x, it.p2_x, it.p3_x, it.frac_u);
            pt.curve_y = spline_axis(it.p0_y, it.p1_y, it.p2_y, it.p3_y, it.frac_u);
            return pt;
        endfunction

        function void note_item(item_t it);
            expected_pts.insert(expected_pts.size(), eval_point(it));
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: x=%0d y=%0d", got.curve_x, got.curve_y);
                return;
            end
            want = expected_pts.pop_front();
            if (got.curve_x !== want.curve_x || got.curve_y !== want.curve_y)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             want.curve_x, want.curve_y, got.curve_x, got.curve_y);
            end
        endfunction

        function int pending();
            return expected_pts.size();
        endfunction

        function int failures();
            return mismatches + expected_pts.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    item_t  item = '0;
    logic   point_valid;
    logic   point_stall = 1'b0;
    point_t point;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    point_scoreboard board;

    cubic_bspline_point_eval_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        point_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Monitor both channels and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                board.note_item(item);
            if (point_valid && !point_stall)
                board.check_point(point);
            if ((item_valid && !item_stall) || (point_valid && !point_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Hold off the sender until every expected point is back.
    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // x takes the given coordinates, y their bitwise complement (max <-> min).
    function automatic item_t pts(coord_t a0, coord_t a1, coord_t a2, coord_t a3, frac_t u);
        item_t it;
        it.p0_x = a0;
        it.p1_x = a1;
        it.p2_x = a2;
        it.p3_x = a3;
        it.p0_y = ~a0;
        it.p1_y = ~a1;
        it.p2_y = ~a2;
        it.p3_y = ~a3;
        it.frac_u = u;
        return it;
    endfunction

    function automatic coord_t pick_coord();
        int mode;
        mode = $urandom_range(9);
        if (mode == 0)
        begin
            case ($urandom_range(3))
                0: return C_MAX;
                1: return C_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (mode <= 2)
            return coord_t'($urandom_range(63)) - coord_t'(32);
        return coord_t'($urandom);
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.p0_x = pick_coord();
        it.p0_y = pick_coord();
        it.p1_x = pick_coord();
        it.p1_y = pick_coord();
        it.p2_x = pick_coord();
        it.p2_y = pick_coord();
        it.p3_x = pick_coord();
        it.p3_y = pick_coord();
        case ($urandom_range(9))
            0: it.frac_u = '0;
            1: it.frac_u = '1;
            2: it.frac_u = frac_t'($urandom_range(255));
            default: it.frac_u = frac_t'($urandom);
        endcase
        return it;
    endfunction

    initial
    begin
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners: extremes, u at both ends, P3 ignored at u = 0, rounding ties.
        send_item(pts('0, '0, '0, '0, '0));
        send_item(pts(C_MAX, C_MAX, C_MAX, C_MAX, '0));
        send_item(pts(C_MAX, C_MAX, C_MAX, C_MAX, '1));
        send_item(pts(C_MAX, C_MAX, C_MAX, C_MAX, 16'h8000));
        send_item(pts(C_MIN, C_MIN, C_MIN, C_MIN, '1));
        send_item(pts(C_MIN, C_MIN, C_MIN, C_MIN, '0));
        send_item(pts(C_MAX, C_MIN, C_MAX, C_MIN, '0));
        send_item(pts(C_MAX, C_MIN, C_MAX, C_MIN, 16'h0001));
        send_item(pts(C_MAX, C_MIN, C_MAX, C_MIN, 16'h8000));
        send_item(pts(C_MAX, C_MIN, C_MAX, C_MIN, '1));
        send_item(pts(C_MIN, C_MAX, C_MIN, C_MAX, '1));
        send_item(pts(C_MIN, C_MAX, C_MIN, C_MAX, 16'h4000));
        send_item(pts('0, '0, '0, C_MAX, '0));
        send_item(pts('0, '0, '0, C_MIN, '1));
        send_item(pts(coord_t'(3), '0, '0, '0, '0));
        send_item(pts(-coord_t'(3), '0, '0, '0, '0));
        send_item(pts(coord_t'(1), '0, '0, '0, '0));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    idle_pct = 21;
                    stall_pct = 21;
                end
            endcase
            repeat (PHASE_ITEMS) send_item(random_item());
            drain();
        end

        stall_pct = 0;
        repeat (SETTLE_TIME) @(posedge clk);
        if (board.failures() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/cbs_pkg.sv
src/cbs_horner_step.sv
src/cbs_div6.sv
src/cbs_axis.sv
src/cubic_bspline_point_eval_unit.sv
test/tb.sv
